// ===== sv/voice_allocator_with_sustain_core_macros.svh =====
// Assertion macros for the voice allocator core.
// Used by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef VOICE_ALLOCATOR_WITH_SUSTAIN_CORE_MACROS_SVH
`define VOICE_ALLOCATOR_WITH_SUSTAIN_CORE_MACROS_SVH

`ifndef SYNTHESIS
// expression must hold at every clock edge outside reset
`define VAS_CHECK(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);
// antecedent implies consequent in the same cycle
`define VAS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define VAS_CHECK(lbl, expr, msg)
`define VAS_IMPLY(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/vas_pkg.sv =====
// Shared constants, types and helpers of the voice allocator.
// No dependencies; imported by the interface, cell and top-level files.
package vas_pkg;

  localparam int VOICES   = 6;
  localparam int AGE_BITS = 16;
  localparam int VIDX_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int VOICE_W  = 3;
  localparam int EV_W     = 2;
  localparam int OP_W     = 2;
  localparam int NOTE_W   = 7;

  typedef logic [VIDX_W-1:0]   vidx_t;
  typedef logic [AGE_BITS-1:0] age_t;
  typedef logic [OP_W-1:0]     op_t;
  typedef logic [EV_W-1:0]     ev_t;
  typedef logic [NOTE_W-1:0]   note_t;

  // operation codes
  localparam op_t OP_NOTE_ON  = 2'd0;
  localparam op_t OP_NOTE_OFF = 2'd1;
  localparam op_t OP_PEDAL    = 2'd2;
  localparam op_t OP_ALL_OFF  = 2'd3;

  // result event codes
  localparam ev_t EV_ASSIGN = 2'd0;
  localparam ev_t EV_STEAL  = 2'd1;
  localparam ev_t EV_KEYOFF = 2'd2;
  localparam ev_t EV_HELD   = 2'd3;

  localparam age_t  AGE_MAX  = '1;
  localparam vidx_t LAST_IDX = vidx_t'(VOICES - 1);

  // token passed from cell to cell during a sweep
  typedef struct packed {
    logic  valid;
    logic  done;        // note-off already matched a voice
    logic  hi_found;    // free voice at or above the pointer
    vidx_t hi_idx;
    logic  lo_found;    // free voice below the pointer
    vidx_t lo_idx;
    logic  best_found;  // oldest active voice so far
    vidx_t best_idx;
    age_t  best_age;
  } carry_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    op_t   op;
    note_t note;
    logic  pedal;
    vidx_t ptr;
    logic  adv;
    logic  claim_en;
    vidx_t claim_idx;
  } cmd_t;

  // one result offered by a cell
  typedef struct packed {
    logic  valid;
    vidx_t idx;
    ev_t   ev;
    logic  last;
  } emit_t;

  // low bits of a voice index as the result field
  function automatic logic [VOICE_W-1:0] voice_field(vidx_t idx);
    logic [VIDX_W+VOICE_W-1:0] ext;
    ext = {{VOICE_W{1'b0}}, idx};
    return ext[VOICE_W-1:0];
  endfunction

endpackage

// ===== sv/vas_intf.sv =====
// Request channel interfaces of the voice allocator: events in, voice results out.
// Depends on vas_pkg.
interface vas_in_if import vas_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  note_t note;
  logic  pedal_down;

  modport source (output valid, operation, note, pedal_down, input ready);
  modport sink   (input valid, operation, note, pedal_down, output ready);
endinterface

interface vas_out_if import vas_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VOICE_W-1:0] voice;
  ev_t                event_res;
  logic               last;

  modport source (output valid, voice, event_res, last, input ready);
  modport sink   (input valid, voice, event_res, last, output ready);
endinterface

// ===== sv/vas_cell.sv =====
// One voice slot: active/held flags, note, age, and the token stage to the next slot.
// Depends on vas_pkg.
module vas_cell import vas_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  vidx_t  idx_i,
  input  cmd_t   cmd_i,
  input  carry_t carry_i,
  input  logic   above_i,
  output carry_t carry_o,
  output emit_t  emit_o,
  output logic   pred_o
);

  logic   active_r, active_nxt;
  logic   held_r, held_nxt;
  note_t  note_r, note_nxt;
  age_t   age_r, age_nxt;
  carry_t carry_r, carry_nxt;
  age_t   age_inc;
  logic   act;

  assign carry_o = carry_r;
  assign act     = carry_i.valid & cmd_i.adv;
  assign age_inc = (age_r == AGE_MAX) ? age_r : age_t'(age_r + 1'b1);

  // would this slot report during the current sweep
  always_comb begin
    unique case (cmd_i.op)
      OP_PEDAL:   pred_o = active_r & held_r;
      OP_ALL_OFF: pred_o = cmd_i.pedal ? active_r : 1'b1;
      default:    pred_o = 1'b0;
    endcase
  end

  // token step and slot update
  always_comb begin
    active_nxt = active_r;
    held_nxt   = held_r;
    note_nxt   = note_r;
    age_nxt    = age_r;
    carry_nxt  = carry_i;
    emit_o     = '0;

    if (act) begin
      unique case (cmd_i.op)
        OP_NOTE_ON: begin
          age_nxt = age_inc;
          if (!active_r) begin
            if (idx_i >= cmd_i.ptr) begin
              if (!carry_i.hi_found) begin
                carry_nxt.hi_found = 1'b1;
                carry_nxt.hi_idx   = idx_i;
              end
            end else if (!carry_i.lo_found) begin
              carry_nxt.lo_found = 1'b1;
              carry_nxt.lo_idx   = idx_i;
            end
          end else if (!carry_i.best_found || age_inc > carry_i.best_age) begin
            carry_nxt.best_found = 1'b1;
            carry_nxt.best_idx   = idx_i;
            carry_nxt.best_age   = age_inc;
          end
        end
        OP_NOTE_OFF: begin
          if (active_r && !held_r && note_r == cmd_i.note && !carry_i.done) begin
            carry_nxt.done = 1'b1;
            emit_o.valid   = 1'b1;
            emit_o.idx     = idx_i;
            emit_o.last    = 1'b1;
            if (cmd_i.pedal) begin
              held_nxt  = 1'b1;
              emit_o.ev = EV_HELD;
            end else begin
              active_nxt = 1'b0;
              emit_o.ev  = EV_KEYOFF;
            end
          end
        end
        OP_PEDAL: begin
          // pedal release
          if (active_r && held_r) begin
            active_nxt   = 1'b0;
            held_nxt     = 1'b0;
            emit_o.valid = 1'b1;
            emit_o.idx   = idx_i;
            emit_o.ev    = EV_KEYOFF;
            emit_o.last  = !above_i;
          end
        end
        OP_ALL_OFF: begin
          if (cmd_i.pedal) begin
            if (active_r) begin
              held_nxt     = 1'b1;
              emit_o.valid = 1'b1;
              emit_o.idx   = idx_i;
              emit_o.ev    = EV_HELD;
              emit_o.last  = !above_i;
            end
          end else begin
            active_nxt   = 1'b0;
            held_nxt     = 1'b0;
            emit_o.valid = 1'b1;
            emit_o.idx   = idx_i;
            emit_o.ev    = EV_KEYOFF;
            emit_o.last  = !above_i;
          end
        end
        default: ;
      endcase
    end

    // note-on claim from the controller after the search
    if (cmd_i.claim_en && cmd_i.claim_idx == idx_i) begin
      active_nxt = 1'b1;
      held_nxt   = 1'b0;
      age_nxt    = '0;
      note_nxt   = cmd_i.note;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      held_r   <= 1'b0;
      age_r    <= '0;
      carry_r  <= '0;
    end else begin
      active_r <= active_nxt;
      held_r   <= held_nxt;
      age_r    <= age_nxt;
      if (cmd_i.adv) begin
        carry_r <= carry_nxt;
      end
    end
  end

  // note payload, meaningful only while active
  always_ff @(posedge clk) begin
    note_r <= note_nxt;
  end

endmodule

// ===== sv/voice_allocator_with_sustain_core.sv =====
// Top level of the voice allocator: controller, chain of voice cells, result register.
// Depends on vas_pkg, vas_intf, vas_cell and the assertion macro header.
//
//   channel | direction | payload                     | done when
//   in_ch   | in        | operation, note, pedal_down | valid && ready
//   out_ch  | out       | voice, event_res, last      | valid && ready
//
// Sweep: a token walks the voice chain one cell per cycle while the result register
// is not stalled; note on, note off, pedal release and all off each run a sweep.
// Pedal press and an unchanged pedal finish in the accepting cycle.
// Reset (rst_n low, synchronous) clears all voice flags, ages, pointer and pedal.
// A stalled result register freezes the token where it stands.
`include "voice_allocator_with_sustain_core_macros.svh"

module voice_allocator_with_sustain_core import vas_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  vas_in_if.sink    in_ch,
  vas_out_if.source out_ch
);

  localparam logic STATE_IDLE  = 1'b0;
  localparam logic STATE_SWEEP = 1'b1;

  logic   state_r, state_nxt;
  op_t    op_r, op_nxt;
  note_t  note_r, note_nxt;
  logic   pedal_r, pedal_nxt;
  vidx_t  ptr_r, ptr_nxt;
  logic   head_r, head_nxt;

  logic   out_valid_r, out_valid_nxt;
  vidx_t  out_idx_r, out_idx_nxt;
  ev_t    out_ev_r, out_ev_nxt;
  logic   out_last_r, out_last_nxt;

  carry_t            chain_in  [VOICES];
  carry_t            chain_out [VOICES];
  emit_t             emit_v    [VOICES];
  logic [VOICES-1:0] pred_vec;
  logic [VOICES-1:0] above;
  logic [VOICES-1:0] tok_vec;
  logic [VOICES:0]   tok_all;
  carry_t            head_carry;
  carry_t            tail;
  cmd_t              cmd;
  emit_t             cell_emit;
  logic              adv;
  logic              claim_en;
  vidx_t             tgt;
  ev_t               tgt_ev;

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == STATE_IDLE);
  assign tail         = chain_out[VOICES-1];

  // note-on target: round-robin free voice, else the oldest one
  always_comb begin
    if (tail.hi_found) begin
      tgt    = tail.hi_idx;
      tgt_ev = EV_ASSIGN;
    end else if (tail.lo_found) begin
      tgt    = tail.lo_idx;
      tgt_ev = EV_ASSIGN;
    end else begin
      tgt    = tail.best_idx;
      tgt_ev = EV_STEAL;
    end
  end

  assign claim_en = (state_r == STATE_SWEEP) && tail.valid && adv && (op_r == OP_NOTE_ON);

  assign cmd.op        = op_r;
  assign cmd.note      = note_r;
  assign cmd.pedal     = pedal_r;
  assign cmd.ptr       = ptr_r;
  assign cmd.adv       = adv;
  assign cmd.claim_en  = claim_en;
  assign cmd.claim_idx = tgt;

  // fresh token entering the first cell
  always_comb begin
    head_carry       = '0;
    head_carry.valid = head_r;
  end

  // voice chain
  genvar gi;
  generate
    for (gi = 0; gi < VOICES; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign chain_in[gi] = head_carry;
      end else begin : g_link
        assign chain_in[gi] = chain_out[gi-1];
      end
      assign above[gi]   = |(pred_vec >> (gi + 1));
      assign tok_vec[gi] = chain_in[gi].valid;

      vas_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .idx_i   (vidx_t'(gi)),
        .cmd_i   (cmd),
        .carry_i (chain_in[gi]),
        .above_i (above[gi]),
        .carry_o (chain_out[gi]),
        .emit_o  (emit_v[gi]),
        .pred_o  (pred_vec[gi])
      );
    end
  endgenerate

  assign tok_all = {tail.valid, tok_vec};

  // only the cell holding the token emits; others drive zero
  always_comb begin
    cell_emit = '0;
    for (int i = 0; i < VOICES; i++) begin
      cell_emit = cell_emit | emit_v[i];
    end
  end

  // controller
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    note_nxt  = note_r;
    pedal_nxt = pedal_r;
    ptr_nxt   = ptr_r;
    head_nxt  = head_r;

    unique case (state_r)
      STATE_IDLE: begin
        if (in_ch.valid) begin
          op_nxt   = in_ch.operation;
          note_nxt = in_ch.note;
          if (in_ch.operation == OP_PEDAL) begin
            if (in_ch.pedal_down != pedal_r) begin
              pedal_nxt = in_ch.pedal_down;
              if (!in_ch.pedal_down) begin
                head_nxt  = 1'b1;
                state_nxt = STATE_SWEEP;
              end
            end
          end else begin
            head_nxt  = 1'b1;
            state_nxt = STATE_SWEEP;
          end
        end
      end
      STATE_SWEEP: begin
        if (head_r && adv) begin
          head_nxt = 1'b0;
        end
        if (tail.valid && adv) begin
          state_nxt = STATE_IDLE;
          if (op_r == OP_NOTE_ON && tgt_ev == EV_ASSIGN) begin
            ptr_nxt = (tgt == LAST_IDX) ? '0 : vidx_t'(tgt + 1'b1);
          end
        end
      end
      default: state_nxt = STATE_IDLE;
    endcase
  end

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_idx_nxt   = out_idx_r;
    out_ev_nxt    = out_ev_r;
    out_last_nxt  = out_last_r;
    if (adv) begin
      out_valid_nxt = cell_emit.valid | claim_en;
      if (claim_en) begin
        out_idx_nxt  = tgt;
        out_ev_nxt   = tgt_ev;
        out_last_nxt = 1'b1;
      end else begin
        out_idx_nxt  = cell_emit.idx;
        out_ev_nxt   = cell_emit.ev;
        out_last_nxt = cell_emit.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_IDLE;
      pedal_r     <= 1'b0;
      ptr_r       <= '0;
      head_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pedal_r     <= pedal_nxt;
      ptr_r       <= ptr_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    note_r     <= note_nxt;
    out_idx_r  <= out_idx_nxt;
    out_ev_r   <= out_ev_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.voice     = voice_field(out_idx_r);
  assign out_ch.event_res = out_ev_r;
  assign out_ch.last      = out_last_r;

  // checks
  `VAS_CHECK(a_one_token, $onehot0(tok_all), "more than one sweep token in the chain")
  `VAS_IMPLY(a_idle_empty, in_ch.ready, tok_all == '0, "token in chain while taking requests")
  `VAS_CHECK(a_ptr_range, ptr_r <= LAST_IDX, "round-robin pointer out of range")
  `VAS_IMPLY(a_emit_room, cell_emit.valid || claim_en, adv, "result offered while output is full")

endmodule
